/* hdl/bmp_stream_to_gray_pixels_macros.svh */
// Assertion macros shared by the BMP gray decoder RTL.
// Depends on nothing; the checks vanish when SYNTHESIS is defined.
`ifndef BMP_STREAM_TO_GRAY_PIXELS_MACROS_SVH
`define BMP_STREAM_TO_GRAY_PIXELS_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check that is switched off while reset is held.
`define BMP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define BMP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMP_ASSERT(label, clk, rst_n, prop, msg)
`define BMP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

/* hdl/bmp_pkg.sv */
// Types, codes and constants of the BMP gray decoder.
// Used by the parser front, the command queue and the pixel back end.
package bmp_pkg;

    localparam int MAX_WIDTH         = 4096;
    localparam int MAX_HEIGHT        = 4096;
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);

    // Error codes carried in the result word.
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_SIGNATURE   = 3'd1,
        ERR_HEADER_SIZE = 3'd2,
        ERR_PLANES      = 3'd3,
        ERR_DEPTH       = 3'd4,
        ERR_COMPRESSION = 3'd5,
        ERR_OFFSET      = 3'd6,
        ERR_TOO_LARGE   = 3'd7
    } t_err;

    // Kinds of command passed from the parser to the back end.
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_DIRECT = 2'd1,
        CMD_INDEX  = 2'd2,
        CMD_ERROR  = 2'd3
    } t_kind;

    // Supported pixel depths.
    localparam logic [4:0] DEPTH_4  = 5'd4;
    localparam logic [4:0] DEPTH_8  = 5'd8;
    localparam logic [4:0] DEPTH_24 = 5'd24;

    // Header byte positions whose arrival completes a field.
    localparam logic [10:0] POS_SIG_B       = 11'd0;
    localparam logic [10:0] POS_SIG_M       = 11'd1;
    localparam logic [10:0] POS_RESERVED    = 11'd9;
    localparam logic [10:0] POS_OFFSET      = 11'd13;
    localparam logic [10:0] POS_HDR_SIZE    = 11'd17;
    localparam logic [10:0] POS_WIDTH       = 11'd21;
    localparam logic [10:0] POS_HEIGHT      = 11'd25;
    localparam logic [10:0] POS_PLANES      = 11'd27;
    localparam logic [10:0] POS_DEPTH       = 11'd29;
    localparam logic [10:0] POS_COMPRESSION = 11'd33;
    localparam logic [10:0] POS_COLORS      = 11'd49;
    localparam logic [10:0] POS_HDR_END     = 11'd53;

    localparam logic [31:0] INFO_HDR_SIZE = 32'd40;

    // One pixel as seen by the back end.
    typedef struct packed {
        logic [7:0]  idx;
        logic        idx_ok;
        logic [11:0] col;
        logic [11:0] row;
        logic        row_end;
        logic        image_end;
    } t_pix;

    // One queued command.
    typedef struct packed {
        t_kind       kind;
        logic        dual;
        logic        bottom_up;
        logic [9:0]  sum;
        t_err        err;
        logic [7:0]  wr_addr;
        logic [23:0] wr_data;
        t_pix        pix0;
        t_pix        pix1;
    } t_cmd;

endpackage

/* hdl/bmp_if.sv */
// Valid/ready channel interfaces of the BMP gray decoder.
// Input words carry file bytes, output words carry gray pixels.
interface bmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       start_of_file;
    modport source(output valid, file_byte, start_of_file, input ready);
    modport sink(input valid, file_byte, start_of_file, output ready);
endinterface

interface bmp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  gray_value;
    logic [11:0] pixel_column;
    logic [11:0] pixel_row;
    logic        row_end;
    logic        image_end;
    logic        rows_bottom_up;
    logic [2:0]  error_code;
    modport source(output valid, gray_value, pixel_column, pixel_row, row_end,
                   image_end, rows_bottom_up, error_code, input ready);
    modport sink(input valid, gray_value, pixel_column, pixel_row, row_end,
                 image_end, rows_bottom_up, error_code, output ready);
endinterface

/* hdl/bmp_front.sv */
// Byte parser: checks headers, tracks palette and pixel positions.
// Depends on bmp_pkg; emits one command per accepted byte at most.
module bmp_front #(
    parameter int PALETTE_DEPTH = bmp_pkg::PALETTE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_byte,
    input  logic          i_sof,
    output logic          o_cmd_valid,
    output bmp_pkg::t_cmd o_cmd
);
    import bmp_pkg::*;

    typedef enum logic [4:0] {
        PH_WAIT    = 5'b00001,
        PH_HEADER  = 5'b00010,
        PH_PALETTE = 5'b00100,
        PH_PIXELS  = 5'b01000,
        PH_DONE    = 5'b10000
    } t_phase;

    t_phase      r_phase, n_phase, cur_phase;
    logic [10:0] r_pos, n_pos, cur_pos;
    logic [31:0] r_field, n_field, cur_field;
    logic [31:0] r_offset, n_offset;
    logic [12:0] r_width, n_width;
    logic [12:0] r_height, n_height;
    logic        r_bu, n_bu;
    logic [4:0]  r_depth, n_depth;
    logic [8:0]  r_pc, n_pc;
    logic [12:0] r_col, n_col;
    logic [11:0] r_row, n_row;
    logic [13:0] r_rbc, n_rbc;
    logic [13:0] r_stride, n_stride;
    logic [15:0] r_partial, n_partial;
    logic [1:0]  r_ci, n_ci;

    logic [31:0] field_sh, mag, colors;
    logic [14:0] row_bytes;
    logic [13:0] stride_c;
    logic        fail_v, do_enter, pix_done;
    t_err        fail_c;
    logic [12:0] col1;
    logic        last0, last1, row_last;
    logic [8:0]  hi_idx, lo_idx, by_idx;

    // Start of file restarts the parser on the current byte.
    assign cur_phase = (i_take && i_sof) ? PH_HEADER : r_phase;
    assign cur_pos   = (i_take && i_sof) ? 11'd0 : r_pos;
    assign cur_field = (i_take && i_sof) ? 32'd0 : r_field;

    // Header field assembly, little endian, newest byte on top.
    assign field_sh = {i_byte, cur_field[31:8]};
    assign mag      = field_sh[31] ? (~field_sh + 32'd1) : field_sh;

    // Padded bytes per row for the current depth.
    always_comb begin
        if (r_depth == DEPTH_24) begin
            row_bytes = {1'b0, r_width, 1'b0} + {2'b00, r_width};
        end else if (r_depth == DEPTH_8) begin
            row_bytes = {2'b00, r_width};
        end else begin
            row_bytes = 15'(({2'b00, r_width} + 15'd1) >> 1);
        end
    end
    assign stride_c = 14'((row_bytes + 15'd3) & ~15'd3);

    // Position flags of the one or two pixels this byte can produce.
    assign col1     = r_col + 13'd1;
    assign last0    = (col1 == r_width);
    assign last1    = ((col1 + 13'd1) == r_width);
    assign row_last = (({1'b0, r_row} + 13'd1) == r_height);
    assign hi_idx   = {5'd0, i_byte[7:4]};
    assign lo_idx   = {5'd0, i_byte[3:0]};
    assign by_idx   = {1'b0, i_byte};

    function automatic t_pix mk_pix(logic [8:0] idx, logic [8:0] pc, logic [12:0] col,
                                    logic [11:0] row, logic last, logic rlast);
        t_pix p;
        p.idx       = idx[7:0];
        p.idx_ok    = (idx < pc) && (idx < 9'(PALETTE_DEPTH));
        p.col       = col[11:0];
        p.row       = row;
        p.row_end   = last;
        p.image_end = last && rlast;
        return p;
    endfunction

    // Next-state logic for one accepted byte.
    always_comb begin
        n_phase   = cur_phase;
        n_pos     = cur_pos;
        n_field   = cur_field;
        n_offset  = r_offset;
        n_width   = r_width;
        n_height  = r_height;
        n_bu      = r_bu;
        n_depth   = r_depth;
        n_pc      = r_pc;
        n_col     = r_col;
        n_row     = r_row;
        n_rbc     = r_rbc;
        n_stride  = r_stride;
        n_partial = r_partial;
        n_ci      = r_ci;
        o_cmd       = '0;
        o_cmd_valid = 1'b0;
        fail_v      = 1'b0;
        fail_c      = ERR_NONE;
        do_enter    = 1'b0;
        pix_done    = 1'b0;
        colors      = field_sh;
        o_cmd.bottom_up = r_bu;
        if (i_take) begin
            case (cur_phase)
                PH_HEADER: begin
                    n_field = field_sh;
                    n_pos   = cur_pos + 11'd1;
                    case (cur_pos)
                        POS_SIG_B: begin
                            if (i_byte != 8'h42) begin
                                fail_v = 1'b1; fail_c = ERR_SIGNATURE;
                            end
                        end
                        POS_SIG_M: begin
                            if (i_byte != 8'h4D) begin
                                fail_v = 1'b1; fail_c = ERR_SIGNATURE;
                            end
                        end
                        POS_RESERVED: begin
                            if (field_sh != 32'd0) begin
                                fail_v = 1'b1; fail_c = ERR_SIGNATURE;
                            end
                        end
                        POS_OFFSET: n_offset = field_sh;
                        POS_HDR_SIZE: begin
                            if (field_sh != INFO_HDR_SIZE) begin
                                fail_v = 1'b1; fail_c = ERR_HEADER_SIZE;
                            end
                        end
                        POS_WIDTH: begin
                            if (mag > 32'(MAX_WIDTH)) begin
                                fail_v = 1'b1; fail_c = ERR_TOO_LARGE;
                            end else begin
                                n_width = mag[12:0];
                            end
                        end
                        POS_HEIGHT: begin
                            n_bu = !field_sh[31] && (field_sh != 32'd0);
                            if (mag > 32'(MAX_HEIGHT)) begin
                                fail_v = 1'b1; fail_c = ERR_TOO_LARGE;
                            end else begin
                                n_height = mag[12:0];
                            end
                        end
                        POS_PLANES: begin
                            if (field_sh[31:16] != 16'd1) begin
                                fail_v = 1'b1; fail_c = ERR_PLANES;
                            end
                        end
                        POS_DEPTH: begin
                            if (field_sh[31:16] != 16'd4 && field_sh[31:16] != 16'd8 &&
                                field_sh[31:16] != 16'd24) begin
                                fail_v = 1'b1; fail_c = ERR_DEPTH;
                            end else begin
                                n_depth = field_sh[20:16];
                            end
                        end
                        POS_COMPRESSION: begin
                            if (field_sh != 32'd0) begin
                                fail_v = 1'b1; fail_c = ERR_COMPRESSION;
                            end
                        end
                        POS_COLORS: begin
                            if (r_depth == DEPTH_24) begin
                                n_pc = 9'd0;
                            end else begin
                                if (field_sh == 32'd0) begin
                                    colors = (r_depth == DEPTH_4) ? 32'd16 : 32'd256;
                                end
                                if (colors > 32'(PALETTE_DEPTH)) begin
                                    fail_v = 1'b1; fail_c = ERR_TOO_LARGE;
                                end else begin
                                    n_pc = colors[8:0];
                                end
                            end
                        end
                        POS_HDR_END: begin
                            if (r_depth == DEPTH_24) begin
                                do_enter = 1'b1;
                            end else begin
                                n_phase   = PH_PALETTE;
                                n_col     = 13'd0;
                                n_ci      = 2'd0;
                                n_partial = 16'd0;
                            end
                        end
                        default: ;
                    endcase
                end
                PH_PALETTE: begin
                    n_pos = cur_pos + 11'd1;
                    case (r_ci)
                        2'd0: n_partial = {8'd0, i_byte};
                        2'd1: n_partial = {i_byte, r_partial[7:0]};
                        2'd2: begin
                            if (r_col < 13'(PALETTE_DEPTH)) begin
                                o_cmd_valid   = 1'b1;
                                o_cmd.kind    = CMD_WRITE;
                                o_cmd.wr_addr = r_col[7:0];
                                o_cmd.wr_data = {i_byte, r_partial};
                            end
                        end
                        default: n_col = r_col + 13'd1;
                    endcase
                    n_ci = r_ci + 2'd1;
                    if (n_ci == 2'd0 && n_col >= {4'd0, r_pc}) begin
                        n_col    = 13'd0;
                        do_enter = 1'b1;
                    end
                end
                PH_PIXELS: begin
                    if (r_col < r_width) begin
                        if (r_depth == DEPTH_24) begin
                            if (r_ci == 2'd0) begin
                                n_partial = {8'd0, i_byte};
                            end else if (r_ci == 2'd1) begin
                                n_partial = r_partial + {8'd0, i_byte};
                            end else begin
                                o_cmd_valid = 1'b1;
                                o_cmd.kind  = CMD_DIRECT;
                                o_cmd.sum   = r_partial[9:0] + {2'd0, i_byte};
                                o_cmd.pix0  = mk_pix(9'd0, r_pc, r_col, r_row, last0,
                                                     row_last);
                                n_col       = col1;
                                pix_done    = last0 && row_last;
                            end
                            n_ci = (r_ci >= 2'd2) ? 2'd0 : r_ci + 2'd1;
                        end else if (r_depth == DEPTH_8) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = CMD_INDEX;
                            o_cmd.pix0  = mk_pix(by_idx, r_pc, r_col, r_row, last0, row_last);
                            n_col       = col1;
                            pix_done    = last0 && row_last;
                        end else begin
                            o_cmd_valid = 1'b1;
                            o_cmd.kind  = CMD_INDEX;
                            o_cmd.pix0  = mk_pix(hi_idx, r_pc, r_col, r_row, last0, row_last);
                            n_col       = col1;
                            pix_done    = last0 && row_last;
                            // Low nibble only while the row still has a column left.
                            if (!pix_done && col1 < r_width) begin
                                o_cmd.dual = 1'b1;
                                o_cmd.pix1 = mk_pix(lo_idx, r_pc, col1, r_row, last1,
                                                    row_last);
                                n_col      = col1 + 13'd1;
                                pix_done   = last1 && row_last;
                            end
                        end
                    end
                    if (pix_done) begin
                        n_phase = PH_DONE;
                    end else if (r_rbc + 14'd1 >= r_stride) begin
                        n_rbc     = 14'd0;
                        n_col     = 13'd0;
                        n_ci      = 2'd0;
                        n_partial = 16'd0;
                        n_row     = r_row + 12'd1;
                    end else begin
                        n_rbc = r_rbc + 14'd1;
                    end
                end
                default: ;
            endcase

            // Entry into pixel data checks the stated offset.
            if (do_enter) begin
                if ({21'd0, n_pos} != n_offset) begin
                    fail_v = 1'b1;
                    fail_c = ERR_OFFSET;
                end else if (r_width == 13'd0 || r_height == 13'd0) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase   = PH_PIXELS;
                    n_col     = 13'd0;
                    n_row     = 12'd0;
                    n_rbc     = 14'd0;
                    n_partial = 16'd0;
                    n_ci      = 2'd0;
                    n_stride  = stride_c;
                end
            end

            // An error sends one error word and stops the file.
            if (fail_v) begin
                n_phase     = PH_DONE;
                o_cmd       = '0;
                o_cmd.kind  = CMD_ERROR;
                o_cmd.err   = fail_c;
                o_cmd_valid = 1'b1;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_pos     <= '0;
            r_field   <= '0;
            r_offset  <= '0;
            r_width   <= '0;
            r_height  <= '0;
            r_bu      <= 1'b0;
            r_depth   <= '0;
            r_pc      <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_rbc     <= '0;
            r_stride  <= '0;
            r_partial <= '0;
            r_ci      <= '0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_field   <= n_field;
            r_offset  <= n_offset;
            r_width   <= n_width;
            r_height  <= n_height;
            r_bu      <= n_bu;
            r_depth   <= n_depth;
            r_pc      <= n_pc;
            r_col     <= n_col;
            r_row     <= n_row;
            r_rbc     <= n_rbc;
            r_stride  <= n_stride;
            r_partial <= n_partial;
            r_ci      <= n_ci;
        end
    end

endmodule

/* hdl/bmp_fifo.sv */
// Short command queue between the parser and the pixel back end.
// Depends on bmp_pkg for the command type and depth.
`include "bmp_stream_to_gray_pixels_macros.svh"
module bmp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bmp_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_valid,
    output bmp_pkg::t_cmd o_data,
    input  logic          i_pop
);
    import bmp_pkg::*;

    t_cmd                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_PTR_W:0]   r_count;

    assign o_full  = (r_count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // Storage of queued commands.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (FIFO_PTR_W+1)'(i_push) - (FIFO_PTR_W+1)'(i_pop);
        end
    end

    `BMP_ASSERT(a_no_overflow, i_clk, i_rst_n, o_full |-> !i_push || i_pop, "queue overflow")
    `BMP_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_valid, "queue underflow")

endmodule

/* hdl/bmp_back.sv */
// Pixel back end: palette memory, color sum and divide by three.
// Depends on bmp_pkg and bmp_out_if; drives the result channel.
`include "bmp_stream_to_gray_pixels_macros.svh"
module bmp_back #(
    parameter int PALETTE_DEPTH = bmp_pkg::PALETTE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  bmp_pkg::t_cmd i_head,
    output logic          o_pop,
    bmp_out_if.source     o_out
);
    import bmp_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [23:0] r_pal_mem [PALETTE_DEPTH];
    logic        r_slot;
    logic        en, is_dual, wr_en, issue;
    t_pix        slot_pix;

    logic        r_s2_v;
    t_kind       r_s2_kind;
    t_pix        r_s2_pix;
    logic [9:0]  r_s2_sum;
    t_err        r_s2_err;
    logic        r_s2_bu;
    logic [23:0] r_pal;

    logic [9:0]  sum;
    logic [20:0] prod;

    logic        r_out_v;
    logic [7:0]  r_gray;
    logic [11:0] r_col, r_row;
    logic        r_row_end, r_image_end, r_bu;
    t_err        r_err;

    // The pipeline moves whenever the output word is free or taken.
    assign en       = !r_out_v || o_out.ready;
    assign is_dual  = (i_head.kind == CMD_INDEX) && i_head.dual;
    assign slot_pix = r_slot ? i_head.pix1 : i_head.pix0;
    assign wr_en    = i_head_valid && en && (i_head.kind == CMD_WRITE);
    assign issue    = i_head_valid && en && (i_head.kind != CMD_WRITE);
    assign o_pop    = i_head_valid && en && (!is_dual || r_slot);

    // Palette memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_pal_mem[i_head.wr_addr[AW-1:0]] <= i_head.wr_data;
        end
        if (en) begin
            r_pal <= r_pal_mem[slot_pix.idx[AW-1:0]];
        end
    end

    // Issue stage: a two-pixel word takes two slots.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= 1'b0;
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= issue;
            if (i_head_valid && is_dual) begin
                r_slot <= !r_slot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_kind <= i_head.kind;
            r_s2_pix  <= slot_pix;
            r_s2_sum  <= i_head.sum;
            r_s2_err  <= i_head.err;
            r_s2_bu   <= i_head.bottom_up;
        end
    end

    // Sum of the three colors, then divide by three via 683/2048.
    always_comb begin
        if (r_s2_kind == CMD_DIRECT) begin
            sum = r_s2_sum;
        end else if (r_s2_pix.idx_ok) begin
            sum = {2'd0, r_pal[7:0]} + {2'd0, r_pal[15:8]} + {2'd0, r_pal[23:16]};
        end else begin
            sum = 10'd0;
        end
    end
    assign prod = {11'd0, sum} * 21'd683;

    // Output word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_s2_kind == CMD_ERROR) begin
                r_gray      <= 8'd0;
                r_col       <= 12'd0;
                r_row       <= 12'd0;
                r_row_end   <= 1'b0;
                r_image_end <= 1'b1;
                r_bu        <= 1'b0;
                r_err       <= r_s2_err;
            end else begin
                r_gray      <= prod[18:11];
                r_col       <= r_s2_pix.col;
                r_row       <= r_s2_pix.row;
                r_row_end   <= r_s2_pix.row_end;
                r_image_end <= r_s2_pix.image_end;
                r_bu        <= r_s2_bu;
                r_err       <= ERR_NONE;
            end
        end
    end

    assign o_out.valid          = r_out_v;
    assign o_out.gray_value     = r_gray;
    assign o_out.pixel_column   = r_col;
    assign o_out.pixel_row      = r_row;
    assign o_out.row_end        = r_row_end;
    assign o_out.image_end      = r_image_end;
    assign o_out.rows_bottom_up = r_bu;
    assign o_out.error_code     = r_err;

    `BMP_ASSERT(a_slot_dual, i_clk, i_rst_n, r_slot |-> i_head_valid && is_dual, "stray slot")
    `BMP_ASSERT(a_err_ends, i_clk, i_rst_n, (r_out_v && r_err != ERR_NONE) |-> r_image_end, "error without end")
    `BMP_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !r_out_v && !r_slot, "reset not idle")

endmodule

/* hdl/bmp_stream_to_gray_pixels.sv */
// Top level of the BMP to gray pixel decoder.
// Depends on bmp_pkg, bmp_if, bmp_front, bmp_fifo and bmp_back.
//
// Use: the file arrives one byte per word on i_in; start_of_file marks
// byte 0 of each file and restarts the parser. Headers are checked, the
// palette is loaded into an internal memory, and every pixel leaves on
// o_out as one word with its gray level, column, row, row and image end
// flags and the row order flag. An error sends a single word with its
// code and image_end set; later bytes of that file are dropped.
// Throughput: one byte per cycle while the queue is not full. A 4-bit
// byte holding two pixels uses the back end's palette read port once
// per pixel, so the queue keeps that word until its second pixel issues.
// On its way out a pixel word is registered in the queue, then at the
// palette read, then after the sum and divide in the output word.
// Reset clears the parser, queue and pipeline; the palette holds junk
// until a file writes it. When the receiver stalls, the pipeline holds
// and the four-word queue keeps taking bytes until it fills.
module bmp_stream_to_gray_pixels #(
    parameter int PALETTE_DEPTH = bmp_pkg::PALETTE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bmp_in_if.sink    i_in,
    bmp_out_if.source o_out
);
    import bmp_pkg::*;

    logic take, cmd_valid, full, head_valid, pop;
    t_cmd cmd, head;

    assign i_in.ready = !full;
    assign take       = i_in.valid && !full;

    bmp_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_byte     (i_in.file_byte),
        .i_sof      (i_in.start_of_file),
        .o_cmd_valid(cmd_valid),
        .o_cmd      (cmd)
    );

    bmp_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (cmd_valid),
        .i_data (cmd),
        .o_full (full),
        .o_valid(head_valid),
        .o_data (head),
        .i_pop  (pop)
    );

    bmp_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_valid(head_valid),
        .i_head      (head),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule
